// ===== rtl/lfl_pkg.sv =====
// Shared types and constants for the linked free-list allocator.
// Depends on nothing; every other file imports it.
package lfl_pkg;

  // pool size and derived widths
  localparam int POOL_CELLS = 256;
  localparam int LINK_W     = $clog2(POOL_CELLS);
  localparam int FIELD_W    = 8;
  localparam int FIELD_MAX  = (1 << FIELD_W) - 1;

  // request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef logic [LINK_W-1:0]  link_t;
  typedef logic [FIELD_W-1:0] field_t;

  // one access to the link memory
  typedef struct packed {
    logic  rd_en;
    link_t rd_addr;
    logic  wr_en;
    link_t wr_addr;
    link_t wr_data;
  } link_req_t;

  // free count reported on the result field, saturated
  function automatic field_t sat_field(link_t v);
    if (32'(v) > FIELD_MAX) begin
      return field_t'(FIELD_MAX);
    end
    return FIELD_W'(v);
  endfunction

endpackage

// ===== rtl/lfl_link_ram.sv =====
// Link memory of the allocator: one write and one registered read port.
// Depends on lfl_pkg for the request struct and widths.
module lfl_link_ram (
  input  logic              clk,
  input  lfl_pkg::link_req_t link_req,
  output lfl_pkg::link_t    rd_data
);
  import lfl_pkg::*;

  link_t mem [POOL_CELLS];
  link_t rd_data_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (link_req.wr_en) begin
      mem[link_req.wr_addr] <= link_req.wr_data;
    end
    if (link_req.rd_en) begin
      rd_data_r <= mem[link_req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/lfl_ctrl.sv =====
// Sequencer of the allocator: walks chains in the link memory, splices
// them, keeps the free count and holds the result register.
// Depends on lfl_pkg; drives lfl_link_ram.
module lfl_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  lfl_pkg::field_t    in_cell_count,
  input  lfl_pkg::field_t    in_chain_head,
  output logic               out_valid,
  input  logic               out_ready,
  output lfl_pkg::field_t    out_new_head,
  output logic               out_failed,
  output lfl_pkg::field_t    out_cells_free,
  output lfl_pkg::link_req_t link_req,
  input  lfl_pkg::link_t     link_rd_data
);
  import lfl_pkg::*;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_A_FIRST,
    ST_A_WALK,
    ST_A_TAIL,
    ST_F_WALK,
    ST_F_HEAD,
    ST_F_LINK0,
    ST_DONE
  } state_t;

  localparam link_t LAST_CELL = link_t'(POOL_CELLS - 1);

  state_t state_r, state_nxt;
  link_t  init_idx_r, init_idx_nxt;
  link_t  free_total_r, free_total_nxt;
  link_t  cur_r, cur_nxt;
  link_t  start_r, start_nxt;
  link_t  steps_r, steps_nxt;
  field_t want_r, want_nxt;
  field_t k_r, k_nxt;
  field_t res_head_r, res_head_nxt;
  logic   res_failed_r, res_failed_nxt;
  logic   out_valid_r, out_valid_nxt;
  field_t out_new_head_r, out_new_head_nxt;
  logic   out_failed_r, out_failed_nxt;
  field_t out_cells_free_r, out_cells_free_nxt;

  field_t          want_in;
  logic [LINK_W:0] free_sum;

  assign want_in  = (in_cell_count == '0) ? field_t'(1) : in_cell_count;
  assign free_sum = {1'b0, free_total_r} + {1'b0, steps_r};

  // next-state logic
  always_comb begin
    state_nxt          = state_r;
    init_idx_nxt       = init_idx_r;
    free_total_nxt     = free_total_r;
    cur_nxt            = cur_r;
    start_nxt          = start_r;
    steps_nxt          = steps_r;
    want_nxt           = want_r;
    k_nxt              = k_r;
    res_head_nxt       = res_head_r;
    res_failed_nxt     = res_failed_r;
    out_valid_nxt      = out_valid_r;
    out_new_head_nxt   = out_new_head_r;
    out_failed_nxt     = out_failed_r;
    out_cells_free_nxt = out_cells_free_r;
    link_req           = '0;

    // result taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // chain every cell to the next one after reset
      ST_INIT: begin
        link_req.wr_en   = 1'b1;
        link_req.wr_addr = init_idx_r;
        link_req.wr_data = (init_idx_r == LAST_CELL) ? '0 : init_idx_r + link_t'(1);
        if (init_idx_r == LAST_CELL) begin
          state_nxt = ST_IDLE;
        end else begin
          init_idx_nxt = init_idx_r + link_t'(1);
        end
      end
      // take a request
      ST_IDLE: begin
        if (in_valid) begin
          res_head_nxt   = '0;
          res_failed_nxt = 1'b0;
          if (in_kind == KIND_ALLOC) begin
            want_nxt = want_in;
            if (32'(want_in) > 32'(free_total_r)) begin
              res_failed_nxt = 1'b1;
              state_nxt      = ST_DONE;
            end else begin
              link_req.rd_en   = 1'b1;
              link_req.rd_addr = '0;
              state_nxt        = ST_A_FIRST;
            end
          end else begin
            if (in_chain_head == '0 || 32'(in_chain_head) >= POOL_CELLS) begin
              state_nxt = ST_DONE;
            end else begin
              start_nxt        = link_t'(in_chain_head);
              cur_nxt          = link_t'(in_chain_head);
              steps_nxt        = link_t'(1);
              link_req.rd_en   = 1'b1;
              link_req.rd_addr = link_t'(in_chain_head);
              state_nxt        = ST_F_WALK;
            end
          end
        end
      end
      // head of the free list arrives
      ST_A_FIRST: begin
        if (link_rd_data == '0) begin
          res_failed_nxt = 1'b1;
          state_nxt      = ST_DONE;
        end else begin
          start_nxt        = link_rd_data;
          cur_nxt          = link_rd_data;
          k_nxt            = field_t'(1);
          link_req.rd_en   = 1'b1;
          link_req.rd_addr = link_rd_data;
          state_nxt        = ST_A_WALK;
        end
      end
      // step along the free list until the chain is long enough
      ST_A_WALK: begin
        if (k_r == want_r) begin
          link_req.wr_en   = 1'b1;
          link_req.wr_addr = '0;
          link_req.wr_data = link_rd_data;
          state_nxt        = ST_A_TAIL;
        end else if (link_rd_data == '0) begin
          res_failed_nxt = 1'b1;
          state_nxt      = ST_DONE;
        end else begin
          cur_nxt          = link_rd_data;
          k_nxt            = k_r + field_t'(1);
          link_req.rd_en   = 1'b1;
          link_req.rd_addr = link_rd_data;
        end
      end
      // terminate the allocated chain
      ST_A_TAIL: begin
        link_req.wr_en   = 1'b1;
        link_req.wr_addr = cur_r;
        link_req.wr_data = '0;
        free_total_nxt   = free_total_r - link_t'(want_r);
        res_head_nxt     = FIELD_W'(start_r);
        state_nxt        = ST_DONE;
      end
      // walk the chain being freed to its end
      ST_F_WALK: begin
        if (link_rd_data != '0) begin
          if (steps_r >= LAST_CELL) begin
            state_nxt = ST_DONE;
          end else begin
            cur_nxt          = link_rd_data;
            steps_nxt        = steps_r + link_t'(1);
            link_req.rd_en   = 1'b1;
            link_req.rd_addr = link_rd_data;
          end
        end else begin
          link_req.rd_en   = 1'b1;
          link_req.rd_addr = '0;
          state_nxt        = ST_F_HEAD;
        end
      end
      // hang the old free list behind the chain's last cell
      ST_F_HEAD: begin
        link_req.wr_en   = 1'b1;
        link_req.wr_addr = cur_r;
        link_req.wr_data = link_rd_data;
        state_nxt        = ST_F_LINK0;
      end
      // chain becomes the new free head, count saturates
      ST_F_LINK0: begin
        link_req.wr_en   = 1'b1;
        link_req.wr_addr = '0;
        link_req.wr_data = start_r;
        if (free_sum > {1'b0, LAST_CELL}) begin
          free_total_nxt = LAST_CELL;
        end else begin
          free_total_nxt = free_sum[LINK_W-1:0];
        end
        state_nxt = ST_DONE;
      end
      // move the result into the output register once it is free
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt      = 1'b1;
          out_new_head_nxt   = res_head_r;
          out_failed_nxt     = res_failed_r;
          out_cells_free_nxt = sat_field(free_total_r);
          state_nxt          = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      init_idx_r   <= '0;
      free_total_r <= LAST_CELL;
      out_valid_r  <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      init_idx_r       <= init_idx_nxt;
      free_total_r     <= free_total_nxt;
      out_valid_r      <= out_valid_nxt;
      cur_r            <= cur_nxt;
      start_r          <= start_nxt;
      steps_r          <= steps_nxt;
      want_r           <= want_nxt;
      k_r              <= k_nxt;
      res_head_r       <= res_head_nxt;
      res_failed_r     <= res_failed_nxt;
      out_new_head_r   <= out_new_head_nxt;
      out_failed_r     <= out_failed_nxt;
      out_cells_free_r <= out_cells_free_nxt;
    end
  end

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_new_head   = out_new_head_r;
  assign out_failed     = out_failed_r;
  assign out_cells_free = out_cells_free_r;

`ifndef SYNTH
  // a refused allocation never names a chain
  a_fail_no_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_failed_r |-> out_new_head_r == '0)
    else $error("failed result carries a chain head");

  // free count stays within the usable cells
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_total_r <= LAST_CELL)
    else $error("free count beyond pool");

  // the sequencer never reads and writes the link memory together
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(link_req.rd_en && link_req.wr_en))
    else $error("read and write to link memory in one cycle");

  // an accepted item leaves the block busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready straight after an accepted item");
`endif

endmodule

// ===== rtl/linked_free_list_allocator.sv =====
// Linked free-list allocator: an allocate of n cells walks n cells of the free list and
// a free of a chain of L cells walks its L cells, at most one link memory access a cycle.
// One item is in work at a time; a result may wait in the output register
// while the next item is accepted.
// After rst_n the link memory is chained in a pass over every cell, during which
// no item is accepted; free count resets to POOL_CELLS-1.
module linked_free_list_allocator (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_kind,
  input  lfl_pkg::field_t in_cell_count,
  input  lfl_pkg::field_t in_chain_head,
  output logic            out_valid,
  input  logic            out_ready,
  output lfl_pkg::field_t out_new_head,
  output logic            out_failed,
  output lfl_pkg::field_t out_cells_free
);
  import lfl_pkg::*;

  link_req_t link_req;
  link_t     link_rd_data;

  // sequencer
  lfl_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_cell_count  (in_cell_count),
    .in_chain_head  (in_chain_head),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_new_head   (out_new_head),
    .out_failed     (out_failed),
    .out_cells_free (out_cells_free),
    .link_req       (link_req),
    .link_rd_data   (link_rd_data)
  );

  // link memory
  lfl_link_ram u_link_ram (
    .clk      (clk),
    .link_req (link_req),
    .rd_data  (link_rd_data)
  );

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the linked free-list allocator.
// Depends on lfl_pkg and linked_free_list_allocator; keeps its own pool model
// and checks every result item against it, in order.
module tb;
  import lfl_pkg::*;

  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 300;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    field_t new_head;
    logic   failed;
    field_t cells_free;
  } request_outcome_t;

  logic   clk = 1'b0;
  logic   rst_n;
  logic   in_valid;
  logic   in_ready;
  logic   in_kind;
  field_t in_cell_count;
  field_t in_chain_head;
  logic   out_valid;
  logic   out_ready;
  field_t out_new_head;
  logic   out_failed;
  field_t out_cells_free;

  // pool model: one next link per cell, plus the free count
  link_t       link_model [POOL_CELLS];
  int unsigned free_model;

  request_outcome_t pending_outcomes[$];
  request_outcome_t last_outcome;
  field_t           live_chains[$];

  int mismatch_count  = 0;
  int items_sent      = 0;
  int frees_sent      = 0;
  int allocs_refused  = 0;
  int results_checked = 0;
  int stalled_cycles  = 0;
  int hold_request    = 0;
  bit in_idle_on      = 1'b0;
  bit out_idle_on     = 1'b0;

  linked_free_list_allocator u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_cell_count (in_cell_count),
    .in_chain_head (in_chain_head),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_new_head  (out_new_head),
    .out_failed    (out_failed),
    .out_cells_free(out_cells_free)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 70);
  endfunction

  // chain length for an allocate: mostly small, a few up to the whole pool
  function automatic field_t pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'd0;
    if (r < 75) return field_t'($urandom_range(1, 6));
    if (r < 93) return field_t'($urandom_range(7, 40));
    return field_t'($urandom_range(41, 255));
  endfunction

  // applies one request to the pool model and returns the result it gives
  function automatic request_outcome_t predict_outcome(logic kind, field_t count,
                                                       field_t head);
    request_outcome_t res;
    int unsigned      wanted, head_cell, cur, k, steps;
    bit               walk_ok;
    res.new_head = '0;
    res.failed   = 1'b0;
    if (kind == KIND_ALLOC) begin
      wanted = (count == 0) ? 1 : count;
      res.failed = 1'b1;
      head_cell = link_model[0];
      // refused when the count is short or the free list runs out early
      if (wanted <= free_model && head_cell != 0) begin
        cur = head_cell;
        walk_ok = 1'b1;
        for (k = 1; k < wanted && walk_ok; k++) begin
          cur = link_model[cur];
          if (cur == 0) walk_ok = 1'b0;
        end
        if (walk_ok) begin
          link_model[0]   = link_model[cur];
          link_model[cur] = '0;
          free_model     -= wanted;
          res.new_head    = field_t'(head_cell);
          res.failed      = 1'b0;
        end
      end
    end else begin
      head_cell = head;
      // cell 0 and cells past the pool are not chains
      if (head_cell != 0 && head_cell < POOL_CELLS) begin
        cur = head_cell;
        steps = 1;
        walk_ok = 1'b1;
        // a chain that never reaches the end marker is left alone
        while (link_model[cur] != 0 && walk_ok) begin
          if (steps >= POOL_CELLS - 1) begin
            walk_ok = 1'b0;
          end else begin
            cur = link_model[cur];
            steps++;
          end
        end
        if (walk_ok) begin
          link_model[cur] = link_model[0];
          link_model[0]   = link_t'(head_cell);
          free_model     += steps;
          if (free_model > POOL_CELLS - 1) free_model = POOL_CELLS - 1;
        end
      end
    end
    res.cells_free = (free_model > FIELD_MAX) ? field_t'(FIELD_MAX) : field_t'(free_model);
    return res;
  endfunction

  // offers one item, waits for it to be taken, then records its result
  task automatic send_request(input logic kind, input field_t count, input field_t head);
    int gap;
    gap = in_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_cell_count <= count;
    in_chain_head <= head;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    last_outcome = predict_outcome(kind, count, head);
    pending_outcomes.push_back(last_outcome);
    items_sent++;
    if (kind == KIND_FREE) frees_sent++;
    else if (last_outcome.failed) allocs_refused++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  // well-formed traffic: frees only of chains that are still held, plus some noise
  task automatic run_traffic(input int n_items);
    int     pick, idx;
    field_t head;
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_request(KIND_FREE, field_t'($urandom), 8'd0);
      end else if (live_chains.size() == 0 || pick < 8 ||
                   pick < ((free_model > 40) ? 62 : 45)) begin
        if (pick < 8) send_request(KIND_ALLOC, field_t'($urandom_range(200, 255)),
                                   field_t'($urandom));
        else send_request(KIND_ALLOC, pick_count(), field_t'($urandom));
        if (!last_outcome.failed) live_chains.push_back(last_outcome.new_head);
      end else begin
        idx  = $urandom_range(0, live_chains.size() - 1);
        head = live_chains[idx];
        live_chains.delete(idx);
        send_request(KIND_FREE, field_t'($urandom), head);
      end
    end
  endtask

  // pool extremes from reset: zero count, empty pool, whole pool, bad head
  task automatic test_extremes();
    field_t one_a, one_b, big, half_a, half_b;
    send_request(KIND_ALLOC, 8'd0, 8'hFF);
    one_a = last_outcome.new_head;
    send_request(KIND_ALLOC, 8'd1, 8'h00);
    one_b = last_outcome.new_head;
    send_request(KIND_FREE, 8'hFF, 8'd0);
    send_request(KIND_ALLOC, 8'd255, 8'h00);
    send_request(KIND_ALLOC, 8'd253, 8'hAA);
    big = last_outcome.new_head;
    send_request(KIND_ALLOC, 8'd1, 8'h55);
    send_request(KIND_ALLOC, 8'd0, 8'h01);
    send_request(KIND_FREE, 8'h00, one_a);
    send_request(KIND_ALLOC, 8'd2, 8'h80);
    send_request(KIND_FREE, 8'h7F, big);
    send_request(KIND_ALLOC, 8'd128, 8'h00);
    half_a = last_outcome.new_head;
    send_request(KIND_ALLOC, 8'd127, 8'h00);
    send_request(KIND_ALLOC, 8'd126, 8'h00);
    half_b = last_outcome.new_head;
    send_request(KIND_FREE, 8'h00, half_b);
    send_request(KIND_FREE, 8'h00, half_a);
    send_request(KIND_FREE, 8'h00, one_b);
    send_request(KIND_ALLOC, 8'd85, 8'h00);
    half_a = last_outcome.new_head;
    send_request(KIND_ALLOC, 8'd170, 8'h00);
    half_b = last_outcome.new_head;
    send_request(KIND_FREE, 8'h00, half_a);
    send_request(KIND_FREE, 8'h00, half_b);
  endtask

  // from a full pool: ring in the free list, looping chain, short free list,
  // then a free that over-counts and saturates, leaving every cell free again
  task automatic test_broken_free_list();
    field_t held, ring_head;
    send_request(KIND_ALLOC, 8'd250, 8'h00);
    held = last_outcome.new_head;
    ring_head = field_t'(link_model[0]);
    send_request(KIND_FREE, 8'h00, ring_head);
    send_request(KIND_FREE, 8'h00, field_t'(link_model[ring_head]));
    send_request(KIND_ALLOC, 8'd3, 8'h00);
    send_request(KIND_ALLOC, 8'd6, 8'h00);
    send_request(KIND_FREE, 8'h00, held);
  endtask

  task automatic test_flat_out();
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    run_traffic(200);
  endtask

  task automatic test_random_gaps();
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    run_traffic(600);
  endtask

  // receiver holds off while items keep coming, so the input side stalls
  task automatic test_output_hold();
    in_idle_on   = 1'b0;
    hold_request = 400;
    run_traffic(30);
  endtask

  task automatic test_drain_pause();
    in_idle_on  = 1'b1;
    out_idle_on = 1'b0;
    run_traffic(150);
    wait_for_results();
    out_idle_on = 1'b1;
    run_traffic(150);
  endtask

  // arbitrary cells freed: double frees, mid-chain frees, loops
  task automatic test_damaged_pool();
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    repeat (350) begin
      if ($urandom_range(0, 1)) send_request(KIND_FREE, field_t'($urandom), field_t'($urandom));
      else send_request(KIND_ALLOC, pick_count(), field_t'($urandom));
    end
  endtask

  // receiver: ready with random stalls, or one long hold when asked
  initial begin
    int stall;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      stall = (out_idle_on && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
      if (hold_request > 0) begin
        stall        = hold_request;
        hold_request = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic report_mismatch(input string what, input int expected, input int actual);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("mismatch on %s at result %0d: expected %0d, got %0d",
               what, results_checked, expected, actual);
  endtask

  // compare each result item with the oldest expectation
  always @(posedge clk) begin
    request_outcome_t exp_item;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("unrequested result", 0, 1);
      end else begin
        exp_item = pending_outcomes.pop_front();
        if (out_new_head !== exp_item.new_head)
          report_mismatch("new_head", exp_item.new_head, out_new_head);
        if (out_failed !== exp_item.failed)
          report_mismatch("failed", exp_item.failed, out_failed);
        if (out_cells_free !== exp_item.cells_free)
          report_mismatch("cells_free", exp_item.cells_free, out_cells_free);
      end
      results_checked++;
    end
  end

  // watchdog on cycles in which no item moves on either side
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_ready === 1'b1) ||
        (out_valid === 1'b1 && out_ready === 1'b1))
      stalled_cycles = 0;
    else
      stalled_cycles++;
    if (stalled_cycles >= STALL_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_outcomes.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_kind       <= KIND_ALLOC;
    in_cell_count <= '0;
    in_chain_head <= '0;
    // pool after reset: every cell links to the next, last one ends the list
    for (int i = 0; i < POOL_CELLS - 1; i++) link_model[i] = link_t'(i + 1);
    link_model[POOL_CELLS - 1] = '0;
    free_model = POOL_CELLS - 1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_extremes();
    test_broken_free_list();
    test_flat_out();
    test_random_gaps();
    test_output_hold();
    test_drain_pause();
    test_damaged_pool();

    // drain, then give any stray result time to show up
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d items sent (%0d frees, %0d allocates refused), %0d results checked",
             items_sent, frees_sent, allocs_refused, results_checked);
    $display("covered pool extremes, broken and looping lists, stalls on both sides");
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
